>>> rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Shared widths, operation codes, operand conversion and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rar_pkg;

   // Port width of one operand field and the number of its low bits in use.
   localparam int OPW          = 32;
   localparam int OPERAND_BITS = 32;

   // Width of products, sums, the gcd and the quotients.
   localparam int DW = 64;

   // Step counter for the serial divider and the gcd's shared power of two.
   localparam int CNT_W = $clog2(DW);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DW - 1);

   localparam logic [OPW:0] OP_MOD  = {{OPW{1'b0}}, 1'b1} << OPERAND_BITS;
   localparam logic [OPW:0] OP_MASK = OP_MOD - {{OPW{1'b0}}, 1'b1};

   localparam logic [DW-1:0] NUM_MAX = {1'b0, {(DW-1){1'b1}}};

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      MS_DEN = 2'd0,
      MS_P1  = 2'd1,
      MS_P2  = 2'd2
   } mul_step_type;

   // Operand as sign and magnitude.
   typedef struct packed {
      logic           neg;
      logic [OPW-1:0] mag;
   } sm32_type;

   // Product or sum as sign and magnitude.
   typedef struct packed {
      logic          neg;
      logic [DW-1:0] mag;
   } sm64_type;

   typedef struct packed {
      logic         load;
      logic         mul;
      mul_step_type mul_step;
      logic         add;
      logic         g_shboth;
      logic         g_sha;
      logic         g_shb;
      logic         g_step;
      logic         g_fin;
      logic         div_step;
      logic         div_load_den;
      logic         out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic bad;
      logic t_zero;
      logic both_even;
      logic a_even;
      logic b_even;
      logic ab_equal;
   } dp_stat_type;

   // Sign-extends the low OPERAND_BITS bits and splits sign and magnitude.
   function automatic sm32_type operand_sm(input logic [OPW-1:0] x);
      logic [OPW:0] v;
      sm32_type     r;
      v     = {1'b0, x} & OP_MASK;
      r.neg = x[OPERAND_BITS-1];
      r.mag = r.neg ? OPW'(OP_MOD - v) : OPW'(v);
      return r;
   endfunction

endpackage

>>> rtl/core/rar_dp.sv
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand registers, shared multiplier, sign-magnitude adder, binary gcd
// registers and a restoring serial divider.
// ----------------------------------------------------------------------------
module rar_dp import rar_pkg::*; (
   input  logic             clock,
   input  op_code_type      req_type,
   input  logic [OPW-1:0]   num_a,
   input  logic [OPW-1:0]   den_a,
   input  logic [OPW-1:0]   num_b,
   input  logic [OPW-1:0]   den_b,
   input  dp_cmd_type       cmd,
   output dp_stat_type      stat,
   output logic [DW-1:0]    res_num,
   output logic [DW-1:0]    res_den,
   output logic             res_bad
);

   op_code_type     op_ff, op_in;
   logic            bad_ff, bad_in;
   sm32_type        an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   sm64_type        den_ff, den_in, p1_ff, p1_in, p2_ff, p2_in, t_ff, t_in;
   logic [DW-1:0]   ga_ff, ga_in, gb_ff, gb_in, gdiv_ff, gdiv_in;
   logic [CNT_W-1:0] gk_ff, gk_in;
   logic [DW-1:0]   dq_ff, dq_in, dr_ff, dr_in, qn_ff, qn_in;

   sm32_type        ld_an, ld_ad, ld_bn, ld_bd;
   sm32_type        mx, my;
   logic [DW-1:0]   prod;
   logic            prod_neg;
   sm64_type        t_comb;
   logic            n2f;
   logic [DW:0]     rsh;
   logic [DW+1:0]   rdiff;

   always_comb begin
      ld_an = operand_sm(num_a);
      ld_ad = operand_sm(den_a);
      ld_bn = operand_sm(num_b);
      ld_bd = operand_sm(den_b);
   end

   // Shared 32x32 multiplier on magnitudes.
   always_comb begin
      case (cmd.mul_step)
         MS_DEN: begin
            mx = ad_ff;
            my = bd_ff;
         end
         MS_P1: begin
            mx = an_ff;
            my = (op_ff == OP_MUL || op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         MS_P2: begin
            mx = bn_ff;
            my = ad_ff;
         end
         default: begin
            mx = ad_ff;
            my = bd_ff;
         end
      endcase
      prod     = DW'(mx.mag) * DW'(my.mag);
      prod_neg = (mx.neg ^ my.neg) && (prod != '0);
   end

   // Numerator from the products, carried as sign and magnitude.
   always_comb begin
      n2f = (op_ff == OP_SUB) ? ((p2_ff.mag != '0) && !p2_ff.neg) : p2_ff.neg;
      if (op_ff == OP_MUL || op_ff == OP_DIV) begin
         t_comb = p1_ff;
      end else if (p1_ff.neg == n2f) begin
         t_comb.mag = p1_ff.mag + p2_ff.mag;
         t_comb.neg = p1_ff.neg;
      end else if (p1_ff.mag >= p2_ff.mag) begin
         t_comb.mag = p1_ff.mag - p2_ff.mag;
         t_comb.neg = p1_ff.neg;
      end else begin
         t_comb.mag = p2_ff.mag - p1_ff.mag;
         t_comb.neg = n2f;
      end
   end

   assign rsh   = {dr_ff, dq_ff[DW-1]};
   assign rdiff = {1'b0, rsh} - {2'b00, gdiv_ff};

   always_comb begin
      op_in   = op_ff;
      bad_in  = bad_ff;
      an_in   = an_ff;
      ad_in   = ad_ff;
      bn_in   = bn_ff;
      bd_in   = bd_ff;
      den_in  = den_ff;
      p1_in   = p1_ff;
      p2_in   = p2_ff;
      t_in    = t_ff;
      ga_in   = ga_ff;
      gb_in   = gb_ff;
      gk_in   = gk_ff;
      gdiv_in = gdiv_ff;
      dq_in   = dq_ff;
      dr_in   = dr_ff;
      qn_in   = qn_ff;

      if (cmd.load) begin
         op_in  = req_type;
         bad_in = (ld_ad.mag == '0) || (ld_bd.mag == '0) ||
                  (req_type == OP_DIV && ld_bn.mag == '0);
         an_in  = ld_an;
         ad_in  = ld_ad;
         if (req_type == OP_DIV) begin
            // Divisor sign moves to its denominator, then the fraction flips.
            bn_in.neg = ld_bd.neg ^ ld_bn.neg;
            bn_in.mag = ld_bd.mag;
            bd_in.neg = 1'b0;
            bd_in.mag = ld_bn.mag;
         end else begin
            bn_in = ld_bn;
            bd_in = ld_bd;
         end
      end

      if (cmd.mul) begin
         case (cmd.mul_step)
            MS_DEN:  den_in = '{neg: prod_neg, mag: prod};
            MS_P1:   p1_in  = '{neg: prod_neg, mag: prod};
            MS_P2:   p2_in  = '{neg: prod_neg, mag: prod};
            default: den_in = den_ff;
         endcase
      end

      if (cmd.add) begin
         t_in  = t_comb;
         ga_in = t_comb.mag;
         gb_in = den_ff.mag;
         gk_in = '0;
      end

      if (cmd.g_shboth) begin
         ga_in = ga_ff >> 1;
         gb_in = gb_ff >> 1;
         gk_in = gk_ff + CNT_W'(1);
      end
      if (cmd.g_sha) begin
         ga_in = ga_ff >> 1;
      end
      if (cmd.g_shb) begin
         gb_in = gb_ff >> 1;
      end
      if (cmd.g_step) begin
         if (ga_ff > gb_ff) begin
            ga_in = gb_ff;
            gb_in = ga_ff - gb_ff;
         end else begin
            gb_in = gb_ff - ga_ff;
         end
      end

      if (cmd.g_fin) begin
         gdiv_in = ga_ff << gk_ff;
         dq_in   = t_ff.mag;
         dr_in   = '0;
      end

      if (cmd.div_step) begin
         if (!rdiff[DW+1]) begin
            dr_in = rdiff[DW-1:0];
            dq_in = {dq_ff[DW-2:0], 1'b1};
         end else begin
            dr_in = rsh[DW-1:0];
            dq_in = {dq_ff[DW-2:0], 1'b0};
         end
      end

      if (cmd.div_load_den) begin
         qn_in = dq_ff;
         dq_in = den_ff.mag;
         dr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      bad_ff  <= bad_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      den_ff  <= den_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      t_ff    <= t_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      gk_ff   <= gk_in;
      gdiv_ff <= gdiv_in;
      dq_ff   <= dq_in;
      dr_ff   <= dr_in;
      qn_ff   <= qn_in;
   end

   always_comb begin
      stat.bad       = bad_ff;
      stat.t_zero    = (t_ff.mag == '0);
      stat.both_even = !ga_ff[0] && !gb_ff[0];
      stat.a_even    = !ga_ff[0];
      stat.b_even    = !gb_ff[0];
      stat.ab_equal  = (ga_ff == gb_ff);
   end

   // Final result: the numerator quotient sits in qn_ff, the denominator's in dq_ff.
   always_comb begin
      if (bad_ff) begin
         res_num = '0;
         res_den = '0;
         res_bad = 1'b1;
      end else if (t_ff.mag == '0) begin
         res_num = '0;
         res_den = DW'(1);
         res_bad = 1'b0;
      end else begin
         if (t_ff.neg) begin
            res_num = '0 - qn_ff;
         end else begin
            res_num = qn_ff[DW-1] ? NUM_MAX : qn_ff;
         end
         res_den = den_ff.neg ? ('0 - dq_ff) : dq_ff;
         res_bad = 1'b0;
      end
   end

endmodule

>>> rtl/core/rar_ctrl.sv
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// One-hot sequencer that steps the datapath through multiply, combine,
// binary gcd and the two serial divisions.
// ----------------------------------------------------------------------------
module rar_ctrl import rar_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        out_free,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE = 13'h0001,
      S_MD   = 13'h0002,
      S_M1   = 13'h0004,
      S_M2   = 13'h0008,
      S_ADD  = 13'h0010,
      S_GSH  = 13'h0020,
      S_GA   = 13'h0040,
      S_GB   = 13'h0080,
      S_GFIN = 13'h0100,
      S_DN   = 13'h0200,
      S_DL   = 13'h0400,
      S_DD   = 13'h0800,
      S_DONE = 13'h1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.mul_step = MS_DEN;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MD;
            end
         end
         S_MD: begin
            cmd.mul      = 1'b1;
            cmd.mul_step = MS_DEN;
            state_in     = stat.bad ? S_DONE : S_M1;
         end
         S_M1: begin
            cmd.mul      = 1'b1;
            cmd.mul_step = MS_P1;
            state_in     = S_M2;
         end
         S_M2: begin
            cmd.mul      = 1'b1;
            cmd.mul_step = MS_P2;
            state_in     = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_GSH;
         end
         S_GSH: begin
            if (stat.t_zero) begin
               state_in = S_DONE;
            end else if (stat.both_even) begin
               cmd.g_shboth = 1'b1;
            end else begin
               state_in = S_GA;
            end
         end
         S_GA: begin
            if (stat.a_even) begin
               cmd.g_sha = 1'b1;
            end else begin
               state_in = S_GB;
            end
         end
         S_GB: begin
            if (stat.b_even) begin
               cmd.g_shb = 1'b1;
            end else begin
               cmd.g_step = 1'b1;
               if (stat.ab_equal) begin
                  state_in = S_GFIN;
               end
            end
         end
         S_GFIN: begin
            cmd.g_fin = 1'b1;
            cnt_in    = '0;
            state_in  = S_DN;
         end
         S_DN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = S_DL;
            end
         end
         S_DL: begin
            cmd.div_load_den = 1'b1;
            cnt_in           = '0;
            state_in         = S_DD;
         end
         S_DD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/core/rational_arith_reduce.sv
// ----------------------------------------------------------------------------
// Rational arithmetic with gcd reduction
// Adds, subtracts, multiplies or divides two signed fractions and returns
// the result reduced by the gcd of its numerator and denominator.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns exactly one result
// transaction for it. The numerator and denominator are formed with a single
// shared 32x32 multiplier, the denominator product first and then the two
// numerator products, combined as sign and magnitude, reduced with a binary
// gcd that moves one shift or one subtract per cycle, and finally divided by
// the gcd with a restoring divider that produces one quotient bit per cycle,
// first for the numerator and then for the denominator. The length of the
// gcd loop depends on the operands. Invalid operands go straight from the
// denominator product to the output, and a zero numerator skips the gcd
// and the divisions. The result sits in an output register, so the next
// transaction is accepted while an earlier result still waits for
// rsp_tready. The denominator keeps the sign the products give it, so it may
// be negative. A zero input denominator, or a divide by a zero fraction,
// returns a zero numerator and denominator with bad_operand set; a zero
// numerator returns 0/1.
module rational_arith_reduce import rar_pkg::*; (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [4*OPW-1:0]  req_tdata,   // num_a, den_a, num_b, den_b
   input  logic [1:0]        req_tuser,   // req_type

   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [2*DW-1:0]   rsp_tdata,   // res_num, res_den
   output logic [0:0]        rsp_tuser    // bad_operand
);

   dp_cmd_type    ctrl_cmd;
   dp_stat_type   dp_stat;
   logic [DW-1:0] res_num;
   logic [DW-1:0] res_den;
   logic          res_bad;
   logic          out_free;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [2*DW-1:0] rsp_data_ff, rsp_data_in;
   logic [0:0]      rsp_user_ff, rsp_user_in;

   // The output slot is free when it is empty or its transaction leaves now.
   assign out_free = !rsp_valid_ff || rsp_tready;

   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   rar_dp u_dp (
      .clock    (clock),
      .req_type (op_code_type'(req_tuser)),
      .num_a    (req_tdata[OPW-1:0]),
      .den_a    (req_tdata[2*OPW-1:OPW]),
      .num_b    (req_tdata[3*OPW-1:2*OPW]),
      .den_b    (req_tdata[4*OPW-1:3*OPW]),
      .cmd      (ctrl_cmd),
      .stat     (dp_stat),
      .res_num  (res_num),
      .res_den  (res_den),
      .res_bad  (res_bad)
   );

   // Output register between the sequencer and the result channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (ctrl_cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_den, res_num};
         rsp_user_in  = res_bad;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A result is only written into the output slot when it is free.
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |-> out_free)
      else $error("result loaded over a pending transaction");

   // One item at a time: after an accepted transaction the input side closes.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while an item is in flight");

   // A flagged result carries a zero numerator and denominator.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("bad operand result is not zero");

   // A valid result always has a nonzero denominator.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[2*DW-1:DW] != '0))
      else $error("zero denominator on a good result");

endmodule
